// File: hw/rtl/mm3_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and bit helpers for the MurmurHash3 x86_32 engine.
// Used by mm3_ctrl, mm3_dpath and murmur3_32_hash; no dependencies.
package mm3_pkg;

  // Hash constants
  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] BODY_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

  // Byte count of a full body block
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // Register index decoded from paddr[2]
  localparam logic [0:0] REG_SEED_IDX = 1'b0;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCR1,
    ST_SCR2,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } mm3_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic start;    // load seed and clear length (message start)
    logic scr1;     // k = word * C1
    logic scr2;     // k = rotl15(k) * C2
    logic mix;      // fold k into the running hash
    logic fin1;     // h = fmix step one
    logic fin2;     // h = fmix step two
    logic emit;     // load the result register
  } mm3_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;     // captured word closes the message
  } mm3_stat_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

  // Keep only the valid low bytes of a word
  function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    mask_bytes = w & m;
  endfunction

endpackage

// File: hw/rtl/mm3_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the MurmurHash3 engine: input and output
// handshakes, message tracking and datapath commands. Depends on mm3_pkg.
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  mm3_stat_t stat_i,
  output mm3_cmd_t  cmd_o
);

  mm3_state_e state_q, state_d;
  logic       in_msg_q, in_msg_d;
  logic       out_valid_q, out_valid_d;

  // State and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    in_msg_d = in_msg_q;
    cmd_o    = '0;
    // drop the result once it is taken
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.start   = !in_msg_q;
          in_msg_d      = 1'b1;
          state_d       = ST_SCR1;
        end
      end
      ST_SCR1: begin
        cmd_o.scr1 = 1'b1;
        state_d    = ST_SCR2;
      end
      ST_SCR2: begin
        cmd_o.scr2 = 1'b1;
        state_d    = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        if (stat_i.last) begin
          in_msg_d = 1'b0;
          state_d  = ST_FIN1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = ST_FIN3;
      end
      ST_FIN3: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // An accepted transaction always starts the scramble sequence
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCR1))
    else $error("accepted transaction did not enter scramble");

  // Never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // A new result only appears after the final finalizer step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN3))
    else $error("result valid raised outside finalize");

  // Finalization only follows the last word of a message
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN1) |-> !in_msg_q)
    else $error("finalize while message still open");
`endif

endmodule

// File: hw/rtl/mm3_dpath.sv
`timescale 1ns / 1ps
// Datapath of the MurmurHash3 engine: word capture, one shared 32x32
// multiplier, running hash, byte length and result register. Depends on mm3_pkg.
module mm3_dpath
  import mm3_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] seed_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  input  mm3_cmd_t    cmd_i,
  output mm3_stat_t   stat_o,
  output logic [31:0] hash_value_o
);

  logic [31:0] k_q;
  logic [31:0] h_q;
  logic [31:0] len_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [31:0] res_q;

  logic [2:0]  cnt_eff;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] fin_x, mix_x, mix_r, mix_h;

  // Non-last words and oversized counts act as full blocks
  assign cnt_eff = (!last_i || (byte_count_i >= FULL_BYTES)) ? FULL_BYTES : byte_count_i;

  // Shared multiplier operand select
  assign fin_x = h_q ^ len_q;
  always_comb begin
    mul_a = rotl15(k_q);
    mul_b = MIX_C2;
    if (cmd_i.scr1) begin
      mul_a = k_q;
      mul_b = MIX_C1;
    end else if (cmd_i.fin1) begin
      mul_a = fin_x ^ (fin_x >> 16);
      mul_b = FIN_M1;
    end else if (cmd_i.fin2) begin
      mul_a = h_q ^ (h_q >> 13);
      mul_b = FIN_M2;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Fold scrambled block into the hash; rotate and add only for full blocks
  assign mix_x = h_q ^ k_q;
  assign mix_r = rotl13(mix_x);
  assign mix_h = (cnt_q == FULL_BYTES) ? (mix_r + (mix_r << 2) + BODY_ADD) : mix_x;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      k_q    <= mask_bytes(data_word_i, cnt_eff);
      cnt_q  <= cnt_eff;
      last_q <= last_i;
    end
    if (cmd_i.start) begin
      h_q   <= seed_i;
      len_q <= '0;
    end
    if (cmd_i.scr1 || cmd_i.scr2) begin
      k_q <= mul_p;
    end
    if (cmd_i.mix) begin
      h_q   <= mix_h;
      len_q <= len_q + {29'd0, cnt_q};
    end
    if (cmd_i.fin1 || cmd_i.fin2) begin
      h_q <= mul_p;
    end
    if (cmd_i.emit) begin
      res_q <= h_q ^ (h_q >> 16);
    end
  end

  assign stat_o.last  = last_q;
  assign hash_value_o = res_q;

endmodule

// File: hw/rtl/murmur3_32_hash.sv
`timescale 1ns / 1ps
// Top level of the MurmurHash3 x86_32 streaming engine: seed register on the
// APB port, controller and datapath. Depends on mm3_pkg, mm3_ctrl, mm3_dpath.

// Words of a message are taken one at a time; a non-last word passes through
// scramble and mix before the next is accepted, and the last word also through
// the finalizer (plus any wait while an earlier result is still stalled in the
// output register), giving one hash per message. This is paced by the single
// shared 32x32 multiplier, which the scramble uses twice and the fmix32
// finalizer twice, each product registered before the next step. The seed
// register (byte address 0, reset 0) is latched at the start of every message,
// so a seed written mid-message applies from the next message on. A result may
// wait in the output register while the next message is already streaming in.
module murmur3_32_hash
  import mm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  // hash results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic        seed_hit;
  mm3_cmd_t    cmd;
  mm3_stat_t   stat;

  // Seed register
  assign pready   = 1'b1;
  assign seed_hit = (paddr[2] == REG_SEED_IDX[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel && penable && pwrite && seed_hit) begin
      seed_q <= pwdata;
    end
  end

  assign prdata = seed_hit ? seed_q : '0;

  mm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mm3_dpath u_dpath (
    .clk_i        (clk_i),
    .seed_i       (seed_q),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .hash_value_o (hash_value_o)
  );

endmodule
